// ===== rtl/mpri_pkg.sv =====
// shared types and constants of the polar ramp interpolator
// no dependencies
package mpri_pkg;

  localparam int NUM_SOURCES_DEF = 16;
  localparam int VAL_W  = 24;
  localparam int ACC_W  = 40;
  localparam int DIFF_W = 42;
  localparam int RED_W  = 43;

  localparam logic [15:0] RAMP_RST = 16'd4410;

  // 2pi and pi in signed Q10.32
  localparam logic signed [RED_W-1:0] TWOPI_Q32    = 43'sd26986086400;
  localparam logic signed [RED_W-1:0] HALFTURN_Q32 = 43'sd13493043200;

  localparam logic signed [ACC_W-1:0] MAX40 = 40'sh7FFFFFFFFF;
  localparam logic signed [ACC_W-1:0] MIN40 = 40'sh8000000000;

  typedef enum logic [1:0] {
    REQ_RAMP   = 2'd0,
    REQ_DIRECT = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SLD,
    ST_WT,
    ST_WC,
    ST_DIFF,
    ST_DIV,
    ST_TRD,
    ST_TEM
  } state_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] cur;
    logic signed [VAL_W-1:0] tgt;
    logic signed [ACC_W-1:0] stp;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/mpri_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating and saturating to 40 bits
// depends on mpri_pkg
module mpri_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mpri_pkg::DIFF_W-1:0]  dividend,
  input  logic [15:0]                         divisor,
  output mpri_pkg::div_sts_t                  sts,
  output logic signed [mpri_pkg::ACC_W-1:0]   quotient
);

  logic [40:0] mag_r, mag_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] div_r;
  logic        neg_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r;
  logic [16:0] rem_sh;
  logic        qbit;
  logic signed [mpri_pkg::DIFF_W-1:0] abs_d;

  assign abs_d  = dividend[mpri_pkg::DIFF_W-1] ? -dividend : dividend;
  assign rem_sh = {rem_r, mag_r[40]};
  assign qbit   = (rem_sh >= {1'b0, div_r});

  always_comb begin
    rem_nxt = qbit ? 16'(rem_sh - {1'b0, div_r}) : rem_sh[15:0];
    mag_nxt = {mag_r[39:0], qbit};
    cnt_nxt = cnt_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 6'd41;
      end else if (cnt_r != 6'd0) begin
        cnt_r <= cnt_nxt;
        if (cnt_r == 6'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= abs_d[40:0];
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[mpri_pkg::DIFF_W-1];
    end else if (cnt_r != 6'd0) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    if (neg_r) begin
      if (mag_r > 41'h8000000000) begin
        quotient = mpri_pkg::MIN40;
      end else begin
        quotient = 40'(-mag_r);
      end
    end else begin
      if (mag_r[40] | mag_r[39]) begin
        quotient = mpri_pkg::MAX40;
      end else begin
        quotient = mag_r[39:0];
      end
    end
  end

  assign sts.busy = (cnt_r != 6'd0);
  assign sts.done = done_r;

endmodule

// ===== rtl/multichannel_polar_ramp_interpolator.sv =====
// top level of the polar ramp interpolator: sequencer, state memory and output register
// depends on mpri_pkg and mpri_div
// A tick transaction walks all 2*NUM_SOURCES entries, each through a read state (ST_TRD) and an
// emit state (ST_TEM) that waits while the output side stalls, emitting radius entries first and
// then azimuth entries. A direct set writes its entry straight from the idle state. A ramped set
// uses the one-bit-per-cycle divider, and an azimuth set first wraps both angles into [0,2pi)
// with the six-step shared subtractor.
// The input is not ready while a transaction is being worked on. No clearing pass after reset.
module multichannel_polar_ramp_interpolator #(
  parameter int NUM_SOURCES = mpri_pkg::NUM_SOURCES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [3:0]         in_source,
  input  logic               in_coord,
  input  logic signed [23:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_source,
  output logic               out_coord,
  output logic signed [23:0] out_value,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int NENT = 2 * NUM_SOURCES;
  localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int RW   = mpri_pkg::RED_W;

  mpri_pkg::state_t state_r, state_nxt;
  mpri_pkg::entry_t mem [NENT];
  mpri_pkg::entry_t rd_q_r, rd_e, wd;
  logic [NENT-1:0]  vld_r;
  logic             rd_v_r;
  logic [AW-1:0]    rd_addr, wa;
  logic             we;

  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             coord_r, coord_nxt;
  logic signed [23:0] val_r, val_nxt;
  logic             snap_r, snap_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic [15:0]      ramp_r;
  logic [15:0]      eff_ramp;
  logic signed [RW-1:0] acc_r, acc_nxt, red_m, red_sub, red_res;
  logic [2:0]       k_r, k_nxt;
  logic signed [RW-1:0] tw_r, tw_nxt, cw_r, cw_nxt;

  logic             div_start;
  logic signed [mpri_pkg::DIFF_W-1:0] div_dividend;
  mpri_pkg::div_sts_t div_sts;
  logic signed [mpri_pkg::ACC_W-1:0] div_q;

  logic             out_valid_r, out_load;
  logic [3:0]       out_source_r, out_source_nxt;
  logic             out_coord_r, out_coord_nxt;
  logic signed [23:0] out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc;
  logic             src_ok;
  logic [AW-1:0]    set_addr;
  logic signed [RW-1:0] val32, rad_diff, ang_gap, az_diff;
  logic signed [40:0] sum41;
  logic signed [mpri_pkg::ACC_W-1:0] sum_sat;
  logic [AW-1:0]    sidx;

  assign eff_ramp  = (ramp_r == 16'd0) ? 16'd1 : ramp_r;
  assign in_ready  = (state_r == mpri_pkg::ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign src_ok    = (32'(in_source) < NUM_SOURCES);
  assign set_addr  = AW'(in_source) + (in_coord ? AW'(NUM_SOURCES) : AW'(0));
  assign rd_addr   = (state_r inside {mpri_pkg::ST_TRD, mpri_pkg::ST_TEM}) ? idx_r : addr_r;
  assign rd_e      = rd_v_r ? rd_q_r : '0;
  assign val32     = {{(RW-40){val_r[23]}}, val_r, 16'b0};
  assign rad_diff  = val32 - {{(RW-40){rd_e.cur[39]}}, rd_e.cur};

  // shared subtractor for the modulo-2pi reduction
  assign red_m   = mpri_pkg::TWOPI_Q32 <<< k_r;
  assign red_sub = acc_r - red_m;
  assign red_res = (acc_r >= red_m) ? red_sub : acc_r;

  assign ang_gap = (cw_r > tw_r) ? (cw_r - tw_r) : (tw_r - cw_r);
  always_comb begin
    if (ang_gap <= mpri_pkg::HALFTURN_Q32) begin
      az_diff = tw_r - cw_r;
    end else if (tw_r > cw_r) begin
      az_diff = (tw_r - mpri_pkg::TWOPI_Q32) - cw_r;
    end else begin
      az_diff = (tw_r + mpri_pkg::TWOPI_Q32) - cw_r;
    end
  end

  assign sum41   = {rd_e.cur[39], rd_e.cur} + {rd_e.stp[39], rd_e.stp};
  assign sum_sat = (sum41[40] != sum41[39]) ?
                   (sum41[40] ? mpri_pkg::MIN40 : mpri_pkg::MAX40) : sum41[39:0];
  assign sidx    = (32'(idx_r) >= NUM_SOURCES) ? (idx_r - AW'(NUM_SOURCES)) : idx_r;

  mpri_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_ramp),
    .sts      (div_sts),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    addr_nxt       = addr_r;
    coord_nxt      = coord_r;
    val_nxt        = val_r;
    snap_nxt       = snap_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    k_nxt          = k_r;
    tw_nxt         = tw_r;
    cw_nxt         = cw_r;
    div_start      = 1'b0;
    div_dividend   = rad_diff[mpri_pkg::DIFF_W-1:0];
    we             = 1'b0;
    wa             = addr_r;
    wd             = rd_e;
    out_load       = 1'b0;
    out_source_nxt = 4'(sidx);
    out_coord_nxt  = (32'(idx_r) >= NUM_SOURCES);
    out_value_nxt  = sum_sat[39:16];
    out_last_nxt   = (32'(idx_r) == NENT - 1);
    case (state_r)
      mpri_pkg::ST_IDLE: begin
        if (in_acc) begin
          addr_nxt  = set_addr;
          coord_nxt = in_coord;
          val_nxt   = in_value;
          case (mpri_pkg::req_t'(in_req_type))
            mpri_pkg::REQ_TICK: begin
              snap_nxt  = (cnt_r >= eff_ramp);
              cnt_nxt   = (cnt_r >= eff_ramp) ? 16'd0 : cnt_r + 16'd1;
              idx_nxt   = '0;
              state_nxt = mpri_pkg::ST_TRD;
            end
            mpri_pkg::REQ_DIRECT: begin
              if (src_ok) begin
                we      = 1'b1;
                wa      = set_addr;
                wd.cur  = {in_value, 16'b0};
                wd.tgt  = in_value;
                wd.stp  = '0;
                cnt_nxt = 16'd0;
              end
            end
            mpri_pkg::REQ_RAMP: begin
              if (src_ok) begin
                state_nxt = mpri_pkg::ST_SRD;
              end
            end
            default: ;
          endcase
        end
      end
      mpri_pkg::ST_SRD: begin
        state_nxt = mpri_pkg::ST_SLD;
      end
      mpri_pkg::ST_SLD: begin
        if (!coord_r) begin
          div_start = 1'b1;
          state_nxt = mpri_pkg::ST_DIV;
        end else begin
          acc_nxt   = val32 + (mpri_pkg::TWOPI_Q32 <<< 5);
          k_nxt     = 3'd5;
          state_nxt = mpri_pkg::ST_WT;
        end
      end
      mpri_pkg::ST_WT: begin
        acc_nxt = red_res;
        k_nxt   = k_r - 3'd1;
        if (k_r == 3'd0) begin
          tw_nxt    = red_res;
          acc_nxt   = {{(RW-40){rd_e.cur[39]}}, rd_e.cur} + (mpri_pkg::TWOPI_Q32 <<< 5);
          k_nxt     = 3'd5;
          state_nxt = mpri_pkg::ST_WC;
        end
      end
      mpri_pkg::ST_WC: begin
        acc_nxt = red_res;
        k_nxt   = k_r - 3'd1;
        if (k_r == 3'd0) begin
          cw_nxt    = red_res;
          state_nxt = mpri_pkg::ST_DIFF;
        end
      end
      mpri_pkg::ST_DIFF: begin
        div_start    = 1'b1;
        div_dividend = az_diff[mpri_pkg::DIFF_W-1:0];
        state_nxt    = mpri_pkg::ST_DIV;
      end
      mpri_pkg::ST_DIV: begin
        if (div_sts.done) begin
          we     = 1'b1;
          wd.stp = div_q;
          if (coord_r) begin
            wd.cur = cw_r[39:0];
            wd.tgt = tw_r[39:16];
          end else begin
            wd.tgt = val_r;
          end
          cnt_nxt   = 16'd0;
          state_nxt = mpri_pkg::ST_IDLE;
        end
      end
      mpri_pkg::ST_TRD: begin
        state_nxt = mpri_pkg::ST_TEM;
      end
      mpri_pkg::ST_TEM: begin
        if (!out_valid_r || out_ready) begin
          we = 1'b1;
          wa = idx_r;
          if (snap_r) begin
            wd.cur        = {rd_e.tgt, 16'b0};
            wd.stp        = '0;
            out_value_nxt = rd_e.tgt;
          end else begin
            wd.cur = sum_sat;
          end
          out_load = 1'b1;
          idx_nxt  = idx_r + AW'(1);
          if (32'(idx_r) == NENT - 1) begin
            state_nxt = mpri_pkg::ST_IDLE;
          end else begin
            state_nxt = mpri_pkg::ST_TRD;
          end
        end
      end
      default: state_nxt = mpri_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpri_pkg::ST_IDLE;
      cnt_r       <= '0;
      ramp_r      <= mpri_pkg::RAMP_RST;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        ramp_r <= cfg_data;
      end
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    coord_r <= coord_nxt;
    val_r   <= val_nxt;
    snap_r  <= snap_nxt;
    acc_r   <= acc_nxt;
    k_r     <= k_nxt;
    tw_r    <= tw_nxt;
    cw_r    <= cw_nxt;
    rd_v_r  <= vld_r[rd_addr];
    if (out_load) begin
      out_source_r <= out_source_nxt;
      out_coord_r  <= out_coord_nxt;
      out_value_r  <= out_value_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // state memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_source = out_source_r;
  assign out_coord  = out_coord_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == mpri_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req_type == mpri_pkg::REQ_TICK) |=>
      (state_r == mpri_pkg::ST_TRD && idx_r == '0))
    else $error("tick transaction did not start its walk at entry zero");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (state_r == mpri_pkg::ST_IDLE))
    else $error("walk continued after the final entry");
`endif

endmodule

// ===== tb/sv/multichannel_polar_ramp_interpolator_tb.sv =====
// testbench of the polar ramp interpolator: directed and random requests, checked against
// a behavioural predictor of the radius and azimuth ramps
// depends on mpri_pkg and multichannel_polar_ramp_interpolator
module multichannel_polar_ramp_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSRC = 16;
  localparam int NCRD = 2 * NSRC;
  localparam longint TURN = 64'sd411775 * 65536;
  localparam longint HALF = TURN / 2;
  localparam longint SAT_HI = 64'sd549755813887;
  localparam longint SAT_LO = -64'sd549755813888;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [3:0]         source;
    logic               coord;
    logic signed [23:0] value;
    logic               last;
  } coord_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = mpri_pkg::REQ_TICK;
  logic [3:0] in_source = '0;
  logic in_coord = 1'b0;
  logic signed [23:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_source;
  logic out_coord;
  logic signed [23:0] out_value;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  longint cur_q32 [NCRD];
  longint tgt_q16 [NCRD];
  longint step_q32 [NCRD];
  int unsigned tick_count;
  int unsigned ramp_len;

  coord_out_t expected_coords [$];
  int unsigned mismatches = 0;
  longint cycles = 0;
  bit stall_free = 1'b0;

  multichannel_polar_ramp_interpolator #(.NUM_SOURCES(NSRC)) i_dut (.*);

  always #10 clk = ~clk;

  function automatic longint clamp40(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint wrap_turn(longint v, longint m);
    longint r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  task automatic predict_request(logic [1:0] req, logic [3:0] src, logic crd,
                                 logic signed [23:0] val);
    longint v, t, t32, c, gap, diff, len;
    bit snap;
    int k;
    coord_out_t o;
    v = longint'(val);
    len = (ramp_len == 0) ? 1 : ramp_len;
    if (req == mpri_pkg::REQ_TICK) begin
      snap = tick_count >= len;
      for (int i = 0; i < NCRD; i++) cur_q32[i] = clamp40(cur_q32[i] + step_q32[i]);
      if (snap) begin
        for (int i = 0; i < NCRD; i++) begin
          cur_q32[i] = tgt_q16[i] * 65536;
          step_q32[i] = 0;
        end
        tick_count = 0;
      end else begin
        tick_count++;
      end
      for (int i = 0; i < NCRD; i++) begin
        o.source = 4'(i % NSRC);
        o.coord = i >= NSRC;
        o.value = 24'(cur_q32[i] >>> 16);
        o.last = i == NCRD - 1;
        expected_coords.push_back(o);
      end
      return;
    end
    if (req == mpri_pkg::REQ_NONE || src >= NSRC) return;
    k = src + (crd ? NSRC : 0);
    if (req == mpri_pkg::REQ_DIRECT) begin
      tgt_q16[k] = v;
      cur_q32[k] = v * 65536;
      step_q32[k] = 0;
    end else if (!crd) begin
      tgt_q16[k] = v;
      step_q32[k] = clamp40((v * 65536 - cur_q32[k]) / len);
    end else begin
      t = wrap_turn(v, 411775);
      t32 = t * 65536;
      c = wrap_turn(cur_q32[k], TURN);
      gap = (c > t32) ? c - t32 : t32 - c;
      tgt_q16[k] = t;
      cur_q32[k] = c;
      if (gap <= HALF) diff = t32 - c;
      else if (t32 > c) diff = (t32 - TURN) - c;
      else diff = (t32 + TURN) - c;
      step_q32[k] = clamp40(diff / len);
    end
    tick_count = 0;
  endtask

  task automatic send_request(logic [1:0] req, logic [3:0] src, logic crd,
                              logic signed [23:0] val);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_source <= src;
    in_coord <= crd;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    predict_request(req, src, crd, val);
  endtask

  task automatic pause_sender(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_ramp_len(logic [15:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    ramp_len = len;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 411774));
      3: return -24'sd411775 + 24'($urandom_range(0, 823550));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    write_ramp_len(16'd1);
    send_request(mpri_pkg::REQ_TICK, 4'd0, 1'b0, '0);
    send_request(mpri_pkg::REQ_DIRECT, 4'd0, 1'b0, 24'sh7FFFFF);
    send_request(mpri_pkg::REQ_DIRECT, 4'd15, 1'b1, 24'sh800000);
    send_request(mpri_pkg::REQ_RAMP, 4'd3, 1'b0, 24'sh800000);
    send_request(mpri_pkg::REQ_RAMP, 4'd15, 1'b1, 24'sh7FFFFF);
    send_request(mpri_pkg::REQ_RAMP, 4'd7, 1'b1, -24'sd1);
    send_request(mpri_pkg::REQ_NONE, 4'd5, 1'b1, 24'sh123456);
    repeat (3) send_request(mpri_pkg::REQ_TICK, 4'd9, 1'b1, 24'sh5A5A5A);
  endtask

  task automatic test_ramp_lengths();
    write_ramp_len(16'd0);
    send_request(mpri_pkg::REQ_RAMP, 4'd2, 1'b0, 24'sd65536);
    send_request(mpri_pkg::REQ_RAMP, 4'd2, 1'b1, 24'sd300000);
    repeat (3) send_request(mpri_pkg::REQ_TICK, 4'd0, 1'b0, '0);
    write_ramp_len(16'hFFFF);
    send_request(mpri_pkg::REQ_RAMP, 4'd1, 1'b1, 24'sd411775);
    send_request(mpri_pkg::REQ_RAMP, 4'd4, 1'b0, -24'sd200000);
    repeat (2) send_request(mpri_pkg::REQ_TICK, 4'd0, 1'b0, '0);
    write_ramp_len(16'd3);
    send_request(mpri_pkg::REQ_DIRECT, 4'd6, 1'b1, 24'sd10);
    send_request(mpri_pkg::REQ_RAMP, 4'd6, 1'b1, 24'sd411700);
    repeat (5) send_request(mpri_pkg::REQ_TICK, 4'd0, 1'b0, '0);
  endtask

  task automatic test_random_traffic();
    logic [1:0] req;
    int burst;
    for (int n = 0; n < 320; n += burst) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++) begin
        req = ($urandom_range(0, 19) == 0) ? mpri_pkg::REQ_NONE : 2'($urandom_range(0, 2));
        send_request(req, 4'($urandom), 1'($urandom), rand_value());
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 8));
      if (n > 100 && n < 115) drain_results();
      if (n > 200 && n < 215) write_ramp_len(16'($urandom_range(1, 6)));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || stall_free) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    coord_out_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (expected_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction src %0d", out_source);
      end else begin
        exp_c = expected_coords.pop_front();
        if (exp_c.source != out_source || exp_c.coord != out_coord ||
            exp_c.value != out_value || exp_c.last != out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d", exp_c.source,
                     exp_c.coord, exp_c.value, exp_c.last, out_source, out_coord,
                     out_value, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NCRD; i++) begin
      cur_q32[i] = 0;
      tgt_q16[i] = 0;
      step_q32[i] = 0;
    end
    tick_count = 0;
    ramp_len = 4410;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_request(mpri_pkg::REQ_DIRECT, 4'd8, 1'b0, 24'sd1000);
    send_request(mpri_pkg::REQ_TICK, 4'd0, 1'b0, '0);
    test_extremes();
    test_ramp_lengths();
    test_random_traffic();
    stall_free = 1'b1;
    drain_results();
    if (mismatches == 0 && expected_coords.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/mpri_pkg.sv
rtl/mpri_div.sv
rtl/multichannel_polar_ramp_interpolator.sv
tb/sv/multichannel_polar_ramp_interpolator_tb.sv
